// ===== rtl/rtc_epoch_calendar_macros.svh =====
// assertion macros for the rtc epoch calendar checker
// expects clk and arst_n in the scope of use
`ifndef RTC_EPOCH_CALENDAR_MACROS_SVH
`define RTC_EPOCH_CALENDAR_MACROS_SVH

// consequent checked in the same cycle
`define RTC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define RTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rtc_cal_pkg.sv =====
// shared types, constants and elaboration helpers for the rtc epoch calendar
// no dependencies
package rtc_cal_pkg;

	localparam int BASE_YEAR_DEF     = 1970;
	localparam int MAX_SET_YEAR_DEF  = 2099;
	localparam int WD_EPOCH_YEAR     = 1900; // 1900-01-01 was a monday
	localparam int YEARS_PER_CENTURY = 100;
	localparam int MONTHS            = 12;
	localparam int LAST_MONTH_IDX    = 11;
	localparam int MAX_MDAY          = 31;
	localparam int DAYS_PER_WEEK     = 7;

	localparam int SEC_PER_DAY  = 86400;
	localparam int SEC_PER_HOUR = 3600;
	localparam int SEC_PER_MIN  = 60;

	localparam int PRESCALE_W = 20;
	localparam int CNT_W      = 32;
	localparam int DN_W       = 16;
	localparam int DAYS_W     = 17;
	localparam int YEAR_W     = 12;
	localparam int MON_W      = 4;
	localparam int DAY_W      = 5;
	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 6;
	localparam int SEC_W      = 6;
	localparam int WD_W       = 3;
	localparam int STEP_W     = 5;

	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 20'd32767;

	typedef enum logic [1:0] {
		ACT_TICK        = 2'd0,
		ACT_READ        = 2'd1,
		ACT_SET_DATE    = 2'd2,
		ACT_SET_SECONDS = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		DIV_DAY  = 2'd0,
		DIV_HOUR = 2'd1,
		DIV_MIN  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     exec;
		logic     walk_init;
		logic     walk_dn;
		logic     year_step;
		logic     month_step;
		logic     walk_sub;
		logic     mul;
		logic     apply_date;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_step;
		logic     cache_commit;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    range_ok;
		logic    yr_hit;
		logic    mon_hit;
		logic    year_fit;
		logic    mon_fit;
		logic    div_last;
		logic    dn_hit;
	} dp_sts_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mi);
		logic [DAY_W-1:0] n;
		case (mi)
			4'd1: n = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic bit is_leap_int(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint days_between(input int from_y, input int to_y);
		longint acc;
		int t;
		acc = 0;
		for (t = from_y; t < to_y; t++) begin
			acc += is_leap_int(t) ? 366 : 365;
		end
		return acc;
	endfunction

endpackage

// ===== rtl/rtc_cal_ctrl.sv =====
// sequencing state machine for the rtc epoch calendar
// depends on rtc_cal_pkg, drives rtc_cal_dp through dp_cmd_t
module rtc_cal_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rtc_cal_pkg::dp_cmd_t cmd,
	input  rtc_cal_pkg::dp_sts_t sts
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_EXEC   = 15'h0002,
		S_SYEAR  = 15'h0004,
		S_SMONTH = 15'h0008,
		S_MUL    = 15'h0010,
		S_ADD    = 15'h0020,
		S_DINIT  = 15'h0040,
		S_DDAY   = 15'h0080,
		S_CHECK  = 15'h0100,
		S_DYEAR  = 15'h0200,
		S_DMONTH = 15'h0400,
		S_DHOUR  = 15'h0800,
		S_MINIT  = 15'h1000,
		S_DMIN   = 15'h2000,
		S_OUT    = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.act == rtc_cal_pkg::ACT_SET_DATE && sts.range_ok) begin
					cmd.walk_init = 1'b1;
					state_d       = S_SYEAR;
				end else begin
					state_d = S_DINIT;
				end
			end
			S_SYEAR: begin
				if (sts.yr_hit) begin
					state_d = S_SMONTH;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			S_SMONTH: begin
				if (sts.mon_hit) begin
					state_d = S_MUL;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.apply_date = 1'b1;
				state_d        = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = rtc_cal_pkg::DIV_DAY;
				state_d       = S_DDAY;
			end
			S_DDAY: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.dn_hit) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtc_cal_pkg::DIV_HOUR;
					state_d       = S_DHOUR;
				end else begin
					cmd.walk_init = 1'b1;
					cmd.walk_dn   = 1'b1;
					state_d       = S_DYEAR;
				end
			end
			S_DYEAR: begin
				if (sts.year_fit) begin
					state_d = S_DMONTH;
				end else begin
					cmd.year_step = 1'b1;
					cmd.walk_sub  = 1'b1;
				end
			end
			S_DMONTH: begin
				if (sts.mon_fit) begin
					cmd.cache_commit = 1'b1;
					cmd.div_start    = 1'b1;
					cmd.div_sel      = rtc_cal_pkg::DIV_HOUR;
					state_d          = S_DHOUR;
				end else begin
					cmd.month_step = 1'b1;
					cmd.walk_sub   = 1'b1;
				end
			end
			S_DHOUR: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_MINIT;
				end
			end
			S_MINIT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = rtc_cal_pkg::DIV_MIN;
				state_d       = S_DMIN;
			end
			S_DMIN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				// transfer taken
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/rtc_cal_dp.sv =====
// datapath of the rtc epoch calendar: prescaler, counter, date cache,
// year and month walker and reciprocal divider; depends on rtc_cal_pkg
module rtc_cal_dp #(
	parameter int BASE_YEAR    = rtc_cal_pkg::BASE_YEAR_DEF,
	parameter int MAX_SET_YEAR = rtc_cal_pkg::MAX_SET_YEAR_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rtc_cal_pkg::dp_cmd_t                cmd,
	output rtc_cal_pkg::dp_sts_t                sts,
	input  logic                                cfg_we,
	input  logic [rtc_cal_pkg::PRESCALE_W-1:0]  cfg_data,
	input  logic [1:0]                          action,
	input  logic [15:0]                         set_year,
	input  logic [7:0]                          set_month,
	input  logic [7:0]                          set_day,
	input  logic [4:0]                          set_hour,
	input  logic [5:0]                          set_minute,
	input  logic [5:0]                          set_second,
	input  logic [31:0]                         set_seconds_value,
	output logic [rtc_cal_pkg::CNT_W-1:0]       seconds_count,
	output logic [rtc_cal_pkg::YEAR_W-1:0]      year,
	output logic [rtc_cal_pkg::MON_W-1:0]       month,
	output logic [rtc_cal_pkg::DAY_W-1:0]       day,
	output logic [rtc_cal_pkg::HOUR_W-1:0]      hour,
	output logic [rtc_cal_pkg::MIN_W-1:0]       minute,
	output logic [rtc_cal_pkg::SEC_W-1:0]       second,
	output logic [rtc_cal_pkg::WD_W-1:0]        weekday,
	output logic                                second_event,
	output logic                                set_error
);

	localparam int BASE_Y100 = BASE_YEAR % rtc_cal_pkg::YEARS_PER_CENTURY;
	localparam int BASE_C4   = (BASE_YEAR / rtc_cal_pkg::YEARS_PER_CENTURY) % 4;
	localparam int WD_OFFSET = int'((rtc_cal_pkg::days_between(rtc_cal_pkg::WD_EPOCH_YEAR,
		BASE_YEAR) + 1) % rtc_cal_pkg::DAYS_PER_WEEK);
	localparam logic [32:0] SEC_LIMIT = 33'(rtc_cal_pkg::days_between(BASE_YEAR,
		MAX_SET_YEAR + 1) * rtc_cal_pkg::SEC_PER_DAY);
	// 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15, 7 for the weekday
	// each reciprocal is 2^k over the odd part rounded up
	localparam logic [25:0] RCP_DAY  = 26'd50903317;
	localparam logic [25:0] RCP_HOUR = 26'd9321;
	localparam logic [25:0] RCP_MIN  = 26'd1093;
	localparam logic [17:0] RCP_WD   = 18'd149797;
	localparam logic [rtc_cal_pkg::STEP_W-1:0] DIV_STEPS = 5'd2;

	// configuration, counter and date cache
	logic [rtc_cal_pkg::PRESCALE_W-1:0] prescale_q, tdiv_q;
	logic [rtc_cal_pkg::CNT_W-1:0]      cnt_q;
	logic [rtc_cal_pkg::DN_W-1:0]       cache_dn_q;
	logic [rtc_cal_pkg::YEAR_W-1:0]     cache_y_q;
	logic [rtc_cal_pkg::MON_W-1:0]      cache_m_q;
	logic [rtc_cal_pkg::DAY_W-1:0]      cache_d_q;

	// captured item
	rtc_cal_pkg::action_t act_q;
	logic [15:0] y_q;
	logic [7:0]  m_q, d_q;
	logic [4:0]  h_q;
	logic [5:0]  mn_q, s_q;
	logic [31:0] v_q;
	logic        event_q, err_q;

	// walker
	logic [rtc_cal_pkg::YEAR_W-1:0] yr_q;
	logic [6:0]                     y100_q;
	logic [1:0]                     c4_q;
	logic [rtc_cal_pkg::DAYS_W-1:0] days_q;
	logic [rtc_cal_pkg::MON_W-1:0]  mi_q;
	logic [33:0]                    prod_q;
	logic [16:0]                    tset_q;

	// reciprocal divider
	logic [31:0]                    rem_q;
	logic [50:0]                    prod_div_q;
	logic [34:0]                    wd_prod_q;
	logic [rtc_cal_pkg::STEP_W-1:0] steps_q;
	rtc_cal_pkg::div_sel_t          sel_q;
	logic [rtc_cal_pkg::DN_W-1:0]   dn_q;
	logic [rtc_cal_pkg::HOUR_W-1:0] hour_q;
	logic [rtc_cal_pkg::MIN_W-1:0]  min_q;
	logic [rtc_cal_pkg::WD_W-1:0]   wday_q;

	// result register
	logic [rtc_cal_pkg::CNT_W-1:0]  o_cnt_q;
	logic [rtc_cal_pkg::YEAR_W-1:0] o_year_q;
	logic [rtc_cal_pkg::MON_W-1:0]  o_month_q;
	logic [rtc_cal_pkg::DAY_W-1:0]  o_day_q;
	logic [rtc_cal_pkg::HOUR_W-1:0] o_hour_q;
	logic [rtc_cal_pkg::MIN_W-1:0]  o_min_q;
	logic [rtc_cal_pkg::SEC_W-1:0]  o_sec_q;
	logic [rtc_cal_pkg::WD_W-1:0]   o_wday_q;
	logic                           o_event_q, o_err_q;

	logic                           leap;
	logic [8:0]                     ylen;
	logic [rtc_cal_pkg::DAY_W-1:0]  mlen;
	logic                           tick_wrap;
	logic                           range_ok;
	logic                           set_sec_ok;
	logic [34:0]                    sum35;
	logic                           date_fit;
	logic [24:0]                    mul_a;
	logic [25:0]                    mul_b;
	logic [rtc_cal_pkg::DN_W-1:0]   div_q;
	logic [16:0]                    div_d;
	logic [31:0]                    rem_nx;
	logic [16:0]                    wd_x;

	function automatic logic [rtc_cal_pkg::DAY_W-1:0] DAY_INC(input logic b);
		return {4'd0, b};
	endfunction

	assign leap = ((yr_q[1:0] == 2'd0) && (y100_q != 7'd0)) ||
		((y100_q == 7'd0) && (c4_q == 2'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = rtc_cal_pkg::month_len(mi_q) +
		DAY_INC(mi_q == 4'd1 && leap);

	assign tick_wrap  = (tdiv_q >= prescale_q);
	assign range_ok   = (y_q >= 16'(BASE_YEAR)) && (y_q <= 16'(MAX_SET_YEAR)) &&
		(m_q >= 8'd1) && (m_q <= 8'(rtc_cal_pkg::MONTHS)) &&
		(d_q >= 8'd1) && (d_q <= 8'(rtc_cal_pkg::MAX_MDAY));
	assign set_sec_ok = ({1'b0, v_q} < SEC_LIMIT);
	assign sum35      = 35'(prod_q) + 35'(tset_q);
	assign date_fit   = (sum35[34:32] == 3'd0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_q = '0;
		div_d = '0;
		case (sel_q)
			rtc_cal_pkg::DIV_DAY: begin
				mul_a = rem_q[31:7];
				mul_b = RCP_DAY;
				div_q = prod_div_q[50:35];
				div_d = 17'(rtc_cal_pkg::SEC_PER_DAY);
			end
			rtc_cal_pkg::DIV_HOUR: begin
				mul_a = 25'(rem_q[16:4]);
				mul_b = RCP_HOUR;
				div_q = 16'(prod_div_q[25:21]);
				div_d = 17'(rtc_cal_pkg::SEC_PER_HOUR);
			end
			rtc_cal_pkg::DIV_MIN: begin
				mul_a = 25'(rem_q[11:2]);
				mul_b = RCP_MIN;
				div_q = 16'(prod_div_q[19:14]);
				div_d = 17'(rtc_cal_pkg::SEC_PER_MIN);
			end
			default: begin
			end
		endcase
	end

	assign rem_nx = rem_q - (32'(div_q) * 32'(div_d));
	assign wd_x   = 17'(dn_q) + 17'(WD_OFFSET);

	assign sts.act      = act_q;
	assign sts.range_ok = range_ok;
	assign sts.yr_hit   = (yr_q == y_q[rtc_cal_pkg::YEAR_W-1:0]);
	assign sts.mon_hit  = (({4'd0, mi_q} + 8'd1) >= m_q);
	assign sts.year_fit = (days_q < 17'(ylen));
	assign sts.mon_fit  = (mi_q >= 4'(rtc_cal_pkg::LAST_MONTH_IDX)) || (days_q < 17'(mlen));
	assign sts.div_last = (steps_q == 5'd1);
	assign sts.dn_hit   = (dn_q == cache_dn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= rtc_cal_pkg::PRESCALE_RESET;
			tdiv_q     <= '0;
			cnt_q      <= '0;
			cache_dn_q <= '0;
			cache_y_q  <= 12'(BASE_YEAR);
			cache_m_q  <= 4'd1;
			cache_d_q  <= 5'd1;
		end else begin
			if (cfg_we) begin
				prescale_q <= cfg_data;
			end
			if (cmd.exec && act_q == rtc_cal_pkg::ACT_TICK) begin
				if (tick_wrap) begin
					tdiv_q <= '0;
					cnt_q  <= cnt_q + 32'd1;
				end else begin
					tdiv_q <= tdiv_q + 20'd1;
				end
			end
			if (cmd.exec && act_q == rtc_cal_pkg::ACT_SET_SECONDS && set_sec_ok) begin
				cnt_q <= v_q;
			end
			if (cmd.apply_date && date_fit) begin
				cnt_q <= sum35[31:0];
			end
			if (cmd.cache_commit) begin
				cache_dn_q <= dn_q;
				cache_y_q  <= yr_q;
				cache_m_q  <= mi_q + 4'd1;
				cache_d_q  <= days_q[rtc_cal_pkg::DAY_W-1:0] + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= rtc_cal_pkg::action_t'(action);
			y_q     <= set_year;
			m_q     <= set_month;
			d_q     <= set_day;
			h_q     <= set_hour;
			mn_q    <= set_minute;
			s_q     <= set_second;
			v_q     <= set_seconds_value;
			event_q <= 1'b0;
			err_q   <= 1'b0;
		end
		if (cmd.exec) begin
			case (act_q)
				rtc_cal_pkg::ACT_TICK: begin
					event_q <= tick_wrap;
				end
				rtc_cal_pkg::ACT_SET_DATE: begin
					err_q <= !range_ok;
				end
				rtc_cal_pkg::ACT_SET_SECONDS: begin
					err_q <= !set_sec_ok;
				end
				default: begin
				end
			endcase
		end
		if (cmd.apply_date) begin
			err_q <= !date_fit;
		end

		if (cmd.walk_init) begin
			yr_q   <= 12'(BASE_YEAR);
			y100_q <= 7'(BASE_Y100);
			c4_q   <= 2'(BASE_C4);
			days_q <= cmd.walk_dn ? {1'b0, dn_q} : '0;
			mi_q   <= '0;
		end
		if (cmd.year_step) begin
			days_q <= cmd.walk_sub ? (days_q - 17'(ylen)) : (days_q + 17'(ylen));
			yr_q   <= yr_q + 12'd1;
			if (y100_q == 7'(rtc_cal_pkg::YEARS_PER_CENTURY - 1)) begin
				y100_q <= '0;
				c4_q   <= c4_q + 2'd1;
			end else begin
				y100_q <= y100_q + 7'd1;
			end
		end
		if (cmd.month_step) begin
			days_q <= cmd.walk_sub ? (days_q - 17'(mlen)) : (days_q + 17'(mlen));
			mi_q   <= mi_q + 4'd1;
		end
		if (cmd.mul) begin
			prod_q <= 34'(days_q + 17'(d_q) - 17'd1) * 34'(rtc_cal_pkg::SEC_PER_DAY);
			tset_q <= 17'(h_q) * 17'(rtc_cal_pkg::SEC_PER_HOUR) +
				17'(mn_q) * 17'(rtc_cal_pkg::SEC_PER_MIN) + 17'(s_q);
		end

		if (cmd.div_start) begin
			sel_q   <= cmd.div_sel;
			steps_q <= DIV_STEPS;
			if (cmd.div_sel == rtc_cal_pkg::DIV_DAY) begin
				rem_q <= cnt_q;
			end
		end
		if (cmd.div_step) begin
			steps_q <= steps_q - 5'd1;
			if (steps_q != 5'd1) begin
				prod_div_q <= 51'(mul_a) * 51'(mul_b);
				wd_prod_q  <= 35'(wd_x) * 35'(RCP_WD);
			end else begin
				rem_q <= rem_nx;
				case (sel_q)
					rtc_cal_pkg::DIV_DAY: begin
						dn_q <= div_q;
					end
					rtc_cal_pkg::DIV_HOUR: begin
						hour_q <= div_q[rtc_cal_pkg::HOUR_W-1:0];
						wday_q <= 3'(wd_x - 17'(wd_prod_q[34:20]) * 17'd7);
					end
					rtc_cal_pkg::DIV_MIN: begin
						min_q <= div_q[rtc_cal_pkg::MIN_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end

		if (cmd.out_load) begin
			o_cnt_q   <= cnt_q;
			o_year_q  <= cache_y_q;
			o_month_q <= cache_m_q;
			o_day_q   <= cache_d_q;
			o_hour_q  <= hour_q;
			o_min_q   <= min_q;
			o_sec_q   <= rem_q[rtc_cal_pkg::SEC_W-1:0];
			o_wday_q  <= wday_q;
			o_event_q <= event_q;
			o_err_q   <= err_q;
		end
	end

	assign seconds_count = o_cnt_q;
	assign year          = o_year_q;
	assign month         = o_month_q;
	assign day           = o_day_q;
	assign hour          = o_hour_q;
	assign minute        = o_min_q;
	assign second        = o_sec_q;
	assign weekday       = o_wday_q;
	assign second_event  = o_event_q;
	assign set_error     = o_err_q;

endmodule

// ===== rtl/rtc_epoch_calendar.sv =====
// rtc epoch calendar top level: rtc_cal_ctrl and rtc_cal_dp, uses rtc_cal_pkg
// a set from date walks years and months to form the count, and a change of day
// walks years and months to refresh the date cache, while an unchanged day uses it;
// the walker and reciprocal divider take one item at a time, next item taken the
// cycle after the result is loaded
// arst_n clears counter, prescaler, date cache and control; reload 32767
module rtc_epoch_calendar #(
	parameter int BASE_YEAR    = rtc_cal_pkg::BASE_YEAR_DEF,
	parameter int MAX_SET_YEAR = rtc_cal_pkg::MAX_SET_YEAR_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         action,
	input  logic [15:0]                        set_year,
	input  logic [7:0]                         set_month,
	input  logic [7:0]                         set_day,
	input  logic [4:0]                         set_hour,
	input  logic [5:0]                         set_minute,
	input  logic [5:0]                         set_second,
	input  logic [31:0]                        set_seconds_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rtc_cal_pkg::CNT_W-1:0]      seconds_count,
	output logic [rtc_cal_pkg::YEAR_W-1:0]     year,
	output logic [rtc_cal_pkg::MON_W-1:0]      month,
	output logic [rtc_cal_pkg::DAY_W-1:0]      day,
	output logic [rtc_cal_pkg::HOUR_W-1:0]     hour,
	output logic [rtc_cal_pkg::MIN_W-1:0]      minute,
	output logic [rtc_cal_pkg::SEC_W-1:0]      second,
	output logic [rtc_cal_pkg::WD_W-1:0]       weekday,
	output logic                               second_event,
	output logic                               set_error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rtc_cal_pkg::PRESCALE_W-1:0] prescale_reload
);

	rtc_cal_pkg::dp_cmd_t cmd;
	rtc_cal_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	rtc_cal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rtc_cal_dp #(
		.BASE_YEAR    (BASE_YEAR),
		.MAX_SET_YEAR (MAX_SET_YEAR)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_valid & cfg_ready),
		.cfg_data          (prescale_reload),
		.action            (action),
		.set_year          (set_year),
		.set_month         (set_month),
		.set_day           (set_day),
		.set_hour          (set_hour),
		.set_minute        (set_minute),
		.set_second        (set_second),
		.set_seconds_value (set_seconds_value),
		.seconds_count     (seconds_count),
		.year              (year),
		.month             (month),
		.day               (day),
		.hour              (hour),
		.minute            (minute),
		.second            (second),
		.weekday           (weekday),
		.second_event      (second_event),
		.set_error         (set_error)
	);

endmodule

// ===== rtl/rtc_cal_chk.sv =====
// port-level checker for the rtc epoch calendar, bound to the top level
// depends on rtc_epoch_calendar_macros.svh
`include "rtc_epoch_calendar_macros.svh"

module rtc_cal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] seconds_count,
	input logic [11:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second,
	input logic [2:0]  weekday,
	input logic        second_event,
	input logic        set_error
);

	`RTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(seconds_count) && $stable(year), "stalled result changed")
	`RTC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "second item taken while busy")
	`RTC_ASSERT_SAME(a_date_range, out_valid, month >= 4'd1 && month <= 4'd12 && day >= 5'd1, "month or day out of range")
	`RTC_ASSERT_SAME(a_time_range, out_valid, hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6, "time field out of range")
	`RTC_ASSERT_SAME(a_flag_excl, out_valid, !(second_event && set_error), "event and error together")

endmodule

bind rtc_epoch_calendar rtc_cal_chk u_chk (.*);

// ===== bench/rtc_epoch_calendar_checker.sv =====
// checker for the rtc epoch calendar: watches the request, result and reload channels,
// keeps its own copy of the counter, prescaler and date cache and compares every result
// depends on rtc_cal_pkg
`timescale 1ns / 1ps

module rtc_epoch_calendar_checker
	import rtc_cal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            action,
	input  logic [15:0]           set_year,
	input  logic [7:0]            set_month,
	input  logic [7:0]            set_day,
	input  logic [4:0]            set_hour,
	input  logic [5:0]            set_minute,
	input  logic [5:0]            set_second,
	input  logic [31:0]           set_seconds_value,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [CNT_W-1:0]      seconds_count,
	input  logic [YEAR_W-1:0]     year,
	input  logic [MON_W-1:0]      month,
	input  logic [DAY_W-1:0]      day,
	input  logic [HOUR_W-1:0]     hour,
	input  logic [MIN_W-1:0]      minute,
	input  logic [SEC_W-1:0]      second,
	input  logic [WD_W-1:0]       weekday,
	input  logic                  second_event,
	input  logic                  set_error,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [PRESCALE_W-1:0] prescale_reload,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct {
		logic [CNT_W-1:0]  count;
		logic [YEAR_W-1:0] yr;
		logic [MON_W-1:0]  mon;
		logic [DAY_W-1:0]  mday;
		logic [HOUR_W-1:0] hr;
		logic [MIN_W-1:0]  mins;
		logic [SEC_W-1:0]  secs;
		logic [WD_W-1:0]   wday;
		logic              tick_event;
		logic              rejected;
	} cal_reading_t;

	localparam int unsigned MONTH_LEN [MONTHS] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	cal_reading_t expected_dates [$];
	cal_reading_t popped_reading;
	cal_reading_t fresh_reading;

	logic [PRESCALE_W-1:0] reload;
	logic [PRESCALE_W-1:0] divider;
	logic [CNT_W-1:0]      counter;
	logic [DN_W-1:0]       cached_dn;
	int unsigned           cached_yr;
	int unsigned           cached_mon;
	int unsigned           cached_mday;

	initial mismatches = 0;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned mi);
		int unsigned n;
		n = MONTH_LEN[mi % MONTHS];
		if (mi == 1 && leap_year(y))
			n++;
		return n;
	endfunction

	function automatic void split_day_number(input int unsigned dn, output int unsigned y,
			output int unsigned m, output int unsigned d);
		int unsigned rem;
		int unsigned yr;
		int unsigned mi;
		rem = dn;
		yr = BASE_YEAR_DEF;
		mi = 0;
		while (rem >= (leap_year(yr) ? 366 : 365)) begin
			rem -= leap_year(yr) ? 366 : 365;
			yr++;
		end
		while (mi < LAST_MONTH_IDX && rem >= month_days(yr, mi)) begin
			rem -= month_days(yr, mi);
			mi++;
		end
		y = yr;
		m = mi + 1;
		d = rem + 1;
	endfunction

	function automatic longint unsigned seconds_of_date(input int unsigned y, input int unsigned m,
			input int unsigned d, input int unsigned h, input int unsigned mn, input int unsigned s);
		longint unsigned days;
		int unsigned t;
		days = 0;
		for (t = BASE_YEAR_DEF; t < y; t++)
			days += leap_year(t) ? 366 : 365;
		for (t = 0; t + 1 < m && t < MONTHS; t++)
			days += month_days(y, t);
		days += d - 1;
		return days * SEC_PER_DAY + longint'(h) * SEC_PER_HOUR + longint'(mn) * SEC_PER_MIN + s;
	endfunction

	function automatic int unsigned weekday_of_day(input int unsigned dn);
		longint unsigned total;
		int unsigned t;
		total = dn;
		for (t = WD_EPOCH_YEAR; t < BASE_YEAR_DEF; t++)
			total += leap_year(t) ? 366 : 365;
		return int'((total + 1) % DAYS_PER_WEEK);
	endfunction

	task automatic apply_item(output cal_reading_t r);
		logic              ev;
		logic              err;
		longint unsigned   v;
		int unsigned       y;
		int unsigned       m;
		int unsigned       d;
		int unsigned       dn;
		int unsigned       tod;
		ev = 1'b0;
		err = 1'b0;
		case (action_t'(action))
			ACT_TICK: begin
				if (divider >= reload) begin
					divider = '0;
					counter = counter + 1'b1;
					ev = 1'b1;
				end else begin
					divider = divider + 1'b1;
				end
			end
			ACT_SET_DATE: begin
				if (set_year < BASE_YEAR_DEF || set_year > MAX_SET_YEAR_DEF || set_month < 1 ||
						set_month > MONTHS || set_day < 1 || set_day > MAX_MDAY) begin
					err = 1'b1;
				end else begin
					v = seconds_of_date(set_year, set_month, set_day, set_hour, set_minute,
						set_second);
					if (v > 64'hFFFF_FFFF)
						err = 1'b1;
					else
						counter = v[31:0];
				end
			end
			ACT_SET_SECONDS: begin
				split_day_number(set_seconds_value / SEC_PER_DAY, y, m, d);
				if (y > MAX_SET_YEAR_DEF)
					err = 1'b1;
				else
					counter = set_seconds_value;
			end
			default: ;
		endcase
		dn = counter / SEC_PER_DAY;
		if (dn != cached_dn) begin
			split_day_number(dn, cached_yr, cached_mon, cached_mday);
			cached_dn = dn[DN_W-1:0];
		end
		tod = counter % SEC_PER_DAY;
		r.count = counter;
		r.yr = cached_yr[YEAR_W-1:0];
		r.mon = cached_mon[MON_W-1:0];
		r.mday = cached_mday[DAY_W-1:0];
		r.hr = HOUR_W'(tod / SEC_PER_HOUR);
		r.mins = MIN_W'((tod % SEC_PER_HOUR) / SEC_PER_MIN);
		r.secs = SEC_W'(tod % SEC_PER_MIN);
		r.wday = WD_W'(weekday_of_day(dn));
		r.tick_event = ev;
		r.rejected = err;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload = PRESCALE_RESET;
			divider = '0;
			counter = '0;
			cached_dn = '0;
			cached_yr = BASE_YEAR_DEF;
			cached_mon = 1;
			cached_mday = 1;
			expected_dates.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatches++;
				end else begin
					popped_reading = expected_dates.pop_front();
					compare_field("seconds_count", popped_reading.count, seconds_count);
					compare_field("year", popped_reading.yr, year);
					compare_field("month", popped_reading.mon, month);
					compare_field("day", popped_reading.mday, day);
					compare_field("hour", popped_reading.hr, hour);
					compare_field("minute", popped_reading.mins, minute);
					compare_field("second", popped_reading.secs, second);
					compare_field("weekday", popped_reading.wday, weekday);
					compare_field("second_event", popped_reading.tick_event, second_event);
					compare_field("set_error", popped_reading.rejected, set_error);
				end
			end
			if (in_valid && !in_stall) begin
				apply_item(fresh_reading);
				expected_dates.push_back(fresh_reading);
			end
			if (cfg_valid && cfg_ready)
				reload = prescale_reload;
			outstanding <= expected_dates.size();
		end
	end

endmodule

// ===== bench/tb_rtc_epoch_calendar.sv =====
// top of the rtc epoch calendar bench: clock, reset, request and reload stimulus, verdict
// depends on rtc_cal_pkg, rtc_epoch_calendar and rtc_epoch_calendar_checker
`timescale 1ns / 1ps

module tb_rtc_epoch_calendar;
	import rtc_cal_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int BLOCK_ITEMS    = 100;
	localparam int BLOCKS         = 6;

	typedef struct {
		action_t     act;
		logic [15:0] yr;
		logic [7:0]  mon;
		logic [7:0]  mday;
		logic [4:0]  hr;
		logic [5:0]  mins;
		logic [5:0]  secs;
		logic [31:0] raw;
	} cal_request_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            action;
	logic [15:0]           set_year;
	logic [7:0]            set_month;
	logic [7:0]            set_day;
	logic [4:0]            set_hour;
	logic [5:0]            set_minute;
	logic [5:0]            set_second;
	logic [31:0]           set_seconds_value;
	logic                  out_valid;
	logic                  out_stall;
	logic [CNT_W-1:0]      seconds_count;
	logic [YEAR_W-1:0]     year;
	logic [MON_W-1:0]      month;
	logic [DAY_W-1:0]      day;
	logic [HOUR_W-1:0]     hour;
	logic [MIN_W-1:0]      minute;
	logic [SEC_W-1:0]      second;
	logic [WD_W-1:0]       weekday;
	logic                  second_event;
	logic                  set_error;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [PRESCALE_W-1:0] prescale_reload;

	int mismatch_count;
	int outstanding;
	int send_idle_pct = 14;
	int recv_idle_pct = 64;
	int quiet_cycles = 0;
	int sent_items = 0;
	int settings_used = 0;

	rtc_epoch_calendar dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.set_year(set_year), .set_month(set_month), .set_day(set_day),
		.set_hour(set_hour), .set_minute(set_minute), .set_second(set_second),
		.set_seconds_value(set_seconds_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.seconds_count(seconds_count), .year(year), .month(month), .day(day),
		.hour(hour), .minute(minute), .second(second), .weekday(weekday),
		.second_event(second_event), .set_error(set_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .prescale_reload(prescale_reload)
	);

	rtc_epoch_calendar_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.set_year(set_year), .set_month(set_month), .set_day(set_day),
		.set_hour(set_hour), .set_minute(set_minute), .set_second(set_second),
		.set_seconds_value(set_seconds_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.seconds_count(seconds_count), .year(year), .month(month), .day(day),
		.hour(hour), .minute(minute), .second(second), .weekday(weekday),
		.second_event(second_event), .set_error(set_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .prescale_reload(prescale_reload),
		.mismatches(mismatch_count), .outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	function automatic cal_request_t noise_request(input action_t act);
		cal_request_t r;
		r.act = act;
		r.yr = 16'($urandom);
		r.mon = 8'($urandom);
		r.mday = 8'($urandom);
		r.hr = 5'($urandom);
		r.mins = 6'($urandom);
		r.secs = 6'($urandom);
		r.raw = $urandom;
		return r;
	endfunction

	function automatic cal_request_t date_request(input int y, input int m, input int d,
			input int h, input int mn, input int s);
		cal_request_t r;
		r = noise_request(ACT_SET_DATE);
		r.yr = 16'(y);
		r.mon = 8'(m);
		r.mday = 8'(d);
		r.hr = 5'(h);
		r.mins = 6'(mn);
		r.secs = 6'(s);
		return r;
	endfunction

	function automatic cal_request_t seconds_request(input logic [31:0] v);
		cal_request_t r;
		r = noise_request(ACT_SET_SECONDS);
		r.raw = v;
		return r;
	endfunction

	function automatic cal_request_t random_request();
		int unsigned pick;
		int unsigned sub;
		longint unsigned v;
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 9);
		if (pick < 45)
			return noise_request(ACT_TICK);
		if (pick < 55)
			return noise_request(ACT_READ);
		if (pick < 78) begin
			if (sub < 7)
				return date_request($urandom_range(BASE_YEAR_DEF, MAX_SET_YEAR_DEF),
					$urandom_range(1, 12), $urandom_range(1, 31),
					(sub == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23),
					(sub == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59),
					(sub == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59));
			if (sub == 7)
				return date_request($urandom_range(0, 1) ? MAX_SET_YEAR_DEF : BASE_YEAR_DEF,
					$urandom_range(0, 1) ? 12 : 1, $urandom_range(0, 1) ? 31 : 1, 23, 59,
					$urandom_range(55, 59));
			return noise_request(ACT_SET_DATE);
		end
		if (sub < 3)
			return noise_request(ACT_SET_SECONDS);
		if (sub < 8) begin
			v = longint'($urandom_range(0, 49709)) * SEC_PER_DAY + SEC_PER_DAY - $urandom_range(1, 5);
			return seconds_request(v[31:0]);
		end
		return seconds_request(32'd4102444797 + $urandom_range(0, 5));
	endfunction

	task automatic send_request(input cal_request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		set_year <= r.yr;
		set_month <= r.mon;
		set_day <= r.mday;
		set_hour <= r.hr;
		set_minute <= r.mins;
		set_second <= r.secs;
		set_seconds_value <= r.raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reload(input logic [PRESCALE_W-1:0] v);
		wait_all_results();
		cfg_valid <= 1'b1;
		prescale_reload <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		action = ACT_READ;
		set_year = '0;
		set_month = '0;
		set_day = '0;
		set_hour = '0;
		set_minute = '0;
		set_second = '0;
		set_seconds_value = '0;
		cfg_valid = 1'b0;
		prescale_reload = PRESCALE_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset date, default prescaler, range checks and odd dates
		send_request(noise_request(ACT_READ));
		send_request(noise_request(ACT_TICK));
		send_request(date_request(1970, 1, 1, 0, 0, 0));
		send_request(date_request(2099, 12, 31, 23, 59, 59));
		send_request(date_request(1969, 6, 15, 12, 0, 0));
		send_request(date_request(2100, 1, 1, 0, 0, 0));
		send_request(date_request(2020, 0, 10, 1, 2, 3));
		send_request(date_request(2020, 13, 10, 1, 2, 3));
		send_request(date_request(2020, 5, 0, 1, 2, 3));
		send_request(date_request(2020, 5, 32, 1, 2, 3));
		send_request(date_request(65535, 255, 255, 31, 63, 63));
		send_request(date_request(2001, 2, 30, 6, 30, 0));
		send_request(date_request(2000, 2, 29, 6, 30, 0));
		send_request(date_request(2000, 2, 30, 6, 30, 0));
		send_request(date_request(2000, 12, 31, 31, 63, 63));
		send_request(seconds_request(32'd0));
		send_request(seconds_request(32'd4102444799));
		send_request(seconds_request(32'd4102444800));
		send_request(seconds_request(32'hFFFF_FFFF));

		// divide by three, then one second per tick across midnight and past the set range
		write_reload(20'd2);
		repeat (4) send_request(noise_request(ACT_TICK));
		write_reload(20'd0);
		send_request(seconds_request(32'd86399));
		send_request(noise_request(ACT_TICK));
		send_request(date_request(2099, 12, 31, 23, 59, 59));
		send_request(noise_request(ACT_TICK));
		send_request(noise_request(ACT_READ));

		for (int b = 0; b < BLOCKS; b++) begin
			case (b)
				0: write_reload(20'd0);
				1: write_reload(20'hFFFFF);
				2: write_reload(20'd3);
				3: write_reload(PRESCALE_W'($urandom_range(0, 15)));
				4: write_reload(20'd1);
				default: write_reload(PRESCALE_W'($urandom));
			endcase
			send_idle_pct <= (b < 2) ? 14 : (b < 4) ? 64 : 0;
			recv_idle_pct <= (b < 2) ? 64 : (b < 4) ? 14 : 0;
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				if ($urandom_range(0, 49) == 0)
					wait_all_results();
				send_request(random_request());
			end
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests (ticks, reads, date and seconds sets) over %0d prescaler settings",
			sent_items, settings_used);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rtc_cal_pkg.sv
rtl/rtc_cal_ctrl.sv
rtl/rtc_cal_dp.sv
rtl/rtc_epoch_calendar.sv
rtl/rtc_cal_chk.sv
bench/rtc_epoch_calendar_checker.sv
bench/tb_rtc_epoch_calendar.sv
